/* rtl/iawr_pkg.sv */
// Package for the indexed array with remove.
// Holds sizes, action and status codes, controller states and the request/result types.
// No dependencies.
package iawr_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int INDEX_W    = 8;
  localparam int COUNT_W    = 9;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_APPEND = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_t;

  typedef struct packed {
    action_t                        action;
    logic [INDEX_W-1:0]             index;
    logic signed [DATA_WIDTH-1:0]   value;
  } request_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]   read_value;
    status_t                        status;
    logic [COUNT_W-1:0]             count;
    logic [COUNT_W-1:0]             capacity;
  } result_t;

endpackage

/* rtl/iawr_mem.sv */
// Entry store of the indexed array: one write port, one read port, registered read data.
// Depends on iawr_pkg for the depth and data width.
module iawr_mem import iawr_pkg::*; (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered; a write to the same address at the edge that samples the
  // address is not visible until the next read.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/indexed_array_with_remove.sv */
// Top level of the indexed array with remove: controller, count and capacity registers.
// Depends on iawr_pkg and instantiates iawr_mem for the entry store.
//
// Usage:
//   A request (action, index, value) is accepted at a rising edge of clk where start is
//   high and busy is low. Every request produces exactly one result, shown on result for
//   one cycle with done high. The receiver cannot stall, so a result is taken in the
//   cycle it appears and never held.
// Sequence from the accepting edge to the cycle in which done is high:
//   - overwrite, append, and every refused request: done follows in the next cycle, and
//     busy stays low, so a new request can be accepted at the very next edge.
//   - successful read: passes through S_READ; the entry store has a registered read port.
//   - successful removal: stays in S_SHIFT until every entry above the index has moved
//     down. The gap is closed by moving one entry per cycle through the single read and
//     single write port of the store, the read of entry j+2 overlapping the write of
//     entry j. Removing the last entry needs no move and answers in the next cycle.
//   busy is high while a read or a removal is still in progress.
// Reset (rst, synchronous, active high) empties the array: count 0, capacity 1, no
// result pending. The entry store is not cleared; only entries below the count are
// ever read, and each of them has been written by an append or a move.
module indexed_array_with_remove import iawr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  state_t               state, state_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [COUNT_W-1:0]   capacity, capacity_next;
  logic [ADDR_W-1:0]    ptr, ptr_next;
  logic                 done_next;
  result_t              result_next;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                  in_range;
  logic                  last_entry;

  iawr_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The index is valid only below the current count.
  assign in_range   = ({1'b0, request.index} < count);
  // Removing the last entry leaves nothing to move.
  assign last_entry = ({1'b0, request.index} == (count - COUNT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      capacity <= COUNT_W'(1);
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      capacity <= capacity_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    result <= result_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    capacity_next = capacity;
    ptr_next      = ptr;
    done_next     = 1'b0;
    result_next   = result;
    mem_we        = 1'b0;
    mem_waddr     = ptr;
    mem_wdata     = mem_rdata;
    mem_raddr     = ADDR_W'(request.index);

    case (state)
      S_IDLE: begin
        if (start) begin
          result_next.read_value = '0;
          result_next.status     = ST_OK;
          case (request.action)
            ACT_READ: begin
              if (in_range) begin
                state_next = S_READ;
              end else begin
                // A failed read returns all ones, that is -1.
                result_next.read_value = '1;
                result_next.status     = ST_RANGE;
                done_next              = 1'b1;
              end
            end
            ACT_WRITE: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(request.index);
                mem_wdata = request.value;
              end else begin
                result_next.status = ST_RANGE;
              end
              done_next = 1'b1;
            end
            ACT_APPEND: begin
              if (count == COUNT_W'(DEPTH)) begin
                result_next.status = ST_FULL;
              end else begin
                // The nominal capacity doubles when an append finds it reached.
                if (count == capacity) begin
                  if ({capacity, 1'b0} > (COUNT_W + 1)'(DEPTH)) begin
                    capacity_next = COUNT_W'(DEPTH);
                  end else begin
                    capacity_next = {capacity[COUNT_W-2:0], 1'b0};
                  end
                end
                mem_we     = 1'b1;
                mem_waddr  = count[ADDR_W-1:0];
                mem_wdata  = request.value;
                count_next = count + COUNT_W'(1);
              end
              done_next = 1'b1;
            end
            ACT_REMOVE: begin
              if (!in_range) begin
                result_next.status = ST_RANGE;
                done_next          = 1'b1;
              end else begin
                count_next = count - COUNT_W'(1);
                if (last_entry) begin
                  done_next = 1'b1;
                end else begin
                  // Fetch the entry above the gap; it is written down next cycle.
                  mem_raddr  = ADDR_W'(request.index) + ADDR_W'(1);
                  ptr_next   = ADDR_W'(request.index);
                  state_next = S_SHIFT;
                end
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
          result_next.count    = count_next;
          result_next.capacity = capacity_next;
        end
      end
      S_READ: begin
        result_next.read_value = mem_rdata;
        done_next              = 1'b1;
        state_next             = S_IDLE;
      end
      S_SHIFT: begin
        // Write entry ptr+1 into ptr while fetching ptr+2. The count already holds the
        // reduced value, so the last destination is count-1.
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        mem_raddr = ptr + ADDR_W'(2);
        ptr_next  = ptr + ADDR_W'(1);
        if (({1'b0, ptr} + COUNT_W'(1)) == count) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // A result only appears once the controller is free again.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while controller busy");

  // The reported count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.count <= COUNT_W'(DEPTH)))
    else $error("count beyond depth");

  // The nominal capacity stays a power of two.
  a_cap_pow2: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot(result.capacity))
    else $error("capacity not a power of two");

  // A successful read waits for the store: busy and no result in the cycle after acceptance.
  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.action == ACT_READ && in_range) |=> (busy && !done))
    else $error("read did not wait for store data");

  // A move never writes at or beyond the reduced count.
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> ({1'b0, ptr} < count))
    else $error("move beyond count");

endmodule

/* sim/tb.sv */
// Testbench for indexed_array_with_remove: directed and random requests checked
// against a cycle-free predictor of the array. Depends on iawr_pkg and the RTL top.
module tb;
  import iawr_pkg::*;

  // A correct run never goes this long without accepting a request or seeing a
  // result: the slowest removal shifts 255 entries and the longest sender gap is the
  // upper bound of the long draw in pick_gap.
  localparam int STALL_LIMIT = 4000;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  logic     done;
  result_t  result;

  indexed_array_with_remove u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predicted array contents, count and nominal capacity. These track the block
  // request by request and are updated at the edge where a request is accepted.
  logic signed [DATA_WIDTH-1:0] model_entries [DEPTH];
  int unsigned model_count    = 0;
  int unsigned model_capacity = 1;

  // Results the block still owes, oldest first.
  result_t pending_results [$];

  int errors          = 0;
  int results_checked = 0;
  int action_tally [4] = '{0, 0, 0, 0};
  int refused_tally   = 0;
  int deepest_count   = 0;
  int idle_run        = 0;
  bit burst_mode      = 1'b0;

  // Applies one request to the predicted array and returns the result it must
  // produce. A read, overwrite or removal at or past the count changes nothing and
  // reports a range error; a failed read returns all ones. An append on a full array is refused.
  // An append that finds the count equal to the capacity doubles the capacity.
  function automatic result_t apply_request(request_t req);
    result_t     r;
    int unsigned i;
    r.read_value = '0;
    r.status     = ST_OK;
    case (req.action)
      ACT_READ: begin
        if (req.index >= model_count) begin
          r.status     = ST_RANGE;
          r.read_value = '1;
        end else begin
          r.read_value = model_entries[req.index];
        end
      end
      ACT_WRITE: begin
        if (req.index >= model_count) r.status = ST_RANGE;
        else model_entries[req.index] = req.value;
      end
      ACT_APPEND: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (model_count == model_capacity)
            model_capacity = (model_capacity * 2 > DEPTH) ? DEPTH : model_capacity * 2;
          model_entries[model_count] = req.value;
          model_count++;
        end
      end
      default: begin
        if (req.index >= model_count) begin
          r.status = ST_RANGE;
        end else begin
          // Close the gap: every later entry moves down one place.
          model_count--;
          for (i = req.index; i < model_count; i++) model_entries[i] = model_entries[i + 1];
        end
      end
    endcase
    r.count    = COUNT_W'(model_count);
    r.capacity = COUNT_W'(model_capacity);
    return r;
  endfunction

  // Idle cycles before the next request: mostly none or a few, now and then a
  // long one, and none at all while a burst stretch is running.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (burst_mode || roll < 45) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Data words lean on the extremes now and then; otherwise fully random.
  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(11, 0))
      0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Builds a request; with in_range set and a non-empty array the index falls on
  // a stored entry, otherwise it is anywhere in the index field.
  function automatic request_t make_request(action_t act, bit in_range);
    request_t req;
    req.action = act;
    req.value  = pick_value();
    if (in_range && model_count > 0)
      req.index = INDEX_W'($urandom_range(model_count - 1, 0));
    else
      req.index = INDEX_W'($urandom_range(255, 0));
    return req;
  endfunction

  // Sends one request after a random gap and returns once it is accepted. start
  // stays high after acceptance, so back-to-back requests need no extra edge;
  // it is lowered only when a gap follows or wait_drained holds off the sender.
  task automatic issue_request(request_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    // busy is sampled before this edge's updates take effect, so a low value here
    // means the block took the request at this very edge.
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(req));
    action_tally[req.action]++;
    if (model_count > deepest_count) deepest_count = model_count;
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic wait_drained();
    if (start) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: every cycle with done high must match the oldest prediction.
  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %p", result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status != ST_OK) refused_tally++;
        if (result.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, result.read_value);
          errors++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result.count);
          errors++;
        end
        if (result.capacity !== want.capacity) begin
          $error("capacity: expected %0d, got %0d", want.capacity, result.capacity);
          errors++;
        end
      end
    end
  end

  // Watchdog: a long stretch with neither an accepted request nor a result means
  // the block has hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Reads, an overwrite and a removal on an empty array are out of range, a read at the top index included.
  task automatic test_empty_array();
    request_t req;
    req = '{action: ACT_READ, index: 8'd0, value: '0};
    issue_request(req);
    req.index = 8'd255;
    issue_request(req);
    req = '{action: ACT_WRITE, index: 8'd0, value: 32'sd5};
    issue_request(req);
    req = '{action: ACT_REMOVE, index: 8'd0, value: '0};
    issue_request(req);
  endtask

  // Extreme data words, capacity growth from 1 to 8, read-back, an overwrite,
  // removal of the last entry (no move) and of the first (full shift), and
  // out-of-range requests just past the count and at the top index.
  task automatic test_edge_values();
    logic signed [DATA_WIDTH-1:0] words [5];
    request_t req;
    words = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1, 32'sd1};
    foreach (words[k]) begin
      req = '{action: ACT_APPEND, index: 8'd0, value: words[k]};
      issue_request(req);
    end
    for (int k = 0; k <= 5; k++) begin
      req = '{action: ACT_READ, index: INDEX_W'(k), value: '0};
      issue_request(req);
    end
    req = '{action: ACT_WRITE, index: 8'd2, value: 32'sha5a5_a5a5};
    issue_request(req);
    req = '{action: ACT_READ, index: 8'd2, value: '0};
    issue_request(req);
    req = '{action: ACT_WRITE, index: 8'd5, value: '1};
    issue_request(req);
    req = '{action: ACT_REMOVE, index: 8'd4, value: '0};
    issue_request(req);
    req = '{action: ACT_REMOVE, index: 8'd0, value: '0};
    issue_request(req);
    req = '{action: ACT_READ, index: 8'd0, value: '0};
    issue_request(req);
    req = '{action: ACT_REMOVE, index: 8'd7, value: '0};
    issue_request(req);
    req = '{action: ACT_READ, index: 8'd255, value: '0};
    issue_request(req);
  endtask

  // Mixed traffic that keeps the array a few dozen entries deep. Appends are
  // favored while it is shallow and removals once it grows, so the count wanders
  // up and down. Most indexes hit stored entries; the rest are random noise.
  // Every third block of 100 requests runs with no gaps, and three times the
  // sender waits for the block to go completely quiet.
  task automatic test_random_mix(int n_requests);
    int unsigned roll;
    int unsigned w_append;
    int unsigned w_remove;
    action_t     act;
    for (int k = 0; k < n_requests; k++) begin
      burst_mode = ((k / 100) % 3 == 2);
      if (k % 500 == 250) wait_drained();
      w_append = (model_count < 24) ? 35 : 15;
      w_remove = (model_count > 40) ? 35 : 20;
      roll = $urandom_range(99, 0);
      if (roll < w_append) act = ACT_APPEND;
      else if (roll < w_append + w_remove) act = ACT_REMOVE;
      else if (roll < w_append + w_remove + 20) act = ACT_WRITE;
      else act = ACT_READ;
      issue_request(make_request(act, $urandom_range(99, 0) < 85));
    end
    burst_mode = 1'b0;
  endtask

  // Fills the array to the last entry so the capacity reaches its ceiling,
  // removes the first entry of a full array (the longest shift), refills it,
  // has appends refused while full, pokes around, then empties it again by
  // removals at random positions.
  task automatic test_fill_and_drain();
    while (model_count < DEPTH) issue_request(make_request(ACT_APPEND, 1'b0));
    issue_request('{action: ACT_REMOVE, index: 8'd0, value: '0});
    issue_request(make_request(ACT_APPEND, 1'b0));
    repeat (3) issue_request(make_request(ACT_APPEND, 1'b0));
    issue_request('{action: ACT_READ, index: 8'd255, value: '0});
    issue_request('{action: ACT_WRITE, index: 8'd255, value: 32'sh1234_5678});
    repeat (20)
      issue_request(make_request($urandom_range(1, 0) ? ACT_READ : ACT_WRITE, 1'b1));
    while (model_count > 0) issue_request(make_request(ACT_REMOVE, 1'b1));
    issue_request('{action: ACT_READ, index: 8'd0, value: '0});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_array();
    test_edge_values();
    test_random_mix(1360);
    test_fill_and_drain();

    // All requests are in; let the last results come home, then a few more
    // cycles to catch any stray done.
    wait_drained();
    repeat (4) @(posedge clk);

    $display("covered: %0d reads, %0d overwrites, %0d appends, %0d removals",
             action_tally[ACT_READ], action_tally[ACT_WRITE],
             action_tally[ACT_APPEND], action_tally[ACT_REMOVE]);
    $display("checked %0d results, %0d refused; array reached %0d entries",
             results_checked, refused_tally, deepest_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
